// ----- rtl/llcu_pkg.sv -----
// Package for the Langton's loop cell update: state and key types, rule table.
// No dependencies.
`default_nettype none
package llcu_pkg;

    localparam int StateW = 3;
    localparam int KeyW   = 5 * StateW;

    typedef logic [StateW-1:0] state_t;
    typedef logic [KeyW-1:0]   key_t;

    typedef struct packed {
        logic   found;
        state_t res;
    } hit_t;

    // key is five octal digits C,N,E,S,W; first listed entry wins
    function automatic hit_t rule_lookup(input key_t key);
        hit_t h;
        h.found = 1'b1;
        h.res   = '0;
        case (key)
            15'o00000: h.res = 3'd0;
            15'o00001: h.res = 3'd2;
            15'o00002: h.res = 3'd0;
            15'o00003: h.res = 3'd0;
            15'o00005: h.res = 3'd0;
            15'o00006: h.res = 3'd3;
            15'o00007: h.res = 3'd1;
            15'o00011: h.res = 3'd2;
            15'o00012: h.res = 3'd2;
            15'o00013: h.res = 3'd2;
            15'o00021: h.res = 3'd2;
            15'o00022: h.res = 3'd0;
            15'o00023: h.res = 3'd0;
            15'o00026: h.res = 3'd2;
            15'o00027: h.res = 3'd2;
            15'o00032: h.res = 3'd0;
            15'o00052: h.res = 3'd5;
            15'o00062: h.res = 3'd2;
            15'o00072: h.res = 3'd2;
            15'o00102: h.res = 3'd2;
            15'o00112: h.res = 3'd0;
            15'o00202: h.res = 3'd0;
            15'o00203: h.res = 3'd0;
            15'o00205: h.res = 3'd0;
            15'o00212: h.res = 3'd5;
            15'o00222: h.res = 3'd0;
            15'o00232: h.res = 3'd2;
            15'o00522: h.res = 3'd2;
            15'o01232: h.res = 3'd1;
            15'o01242: h.res = 3'd1;
            15'o01252: h.res = 3'd5;
            15'o01262: h.res = 3'd1;
            15'o01272: h.res = 3'd1;
            15'o01275: h.res = 3'd1;
            15'o01422: h.res = 3'd1;
            15'o01432: h.res = 3'd1;
            15'o01442: h.res = 3'd1;
            15'o01472: h.res = 3'd1;
            15'o01625: h.res = 3'd1;
            15'o01722: h.res = 3'd1;
            15'o01725: h.res = 3'd5;
            15'o01752: h.res = 3'd1;
            15'o01762: h.res = 3'd1;
            15'o01772: h.res = 3'd1;
            15'o02527: h.res = 3'd1;
            15'o10001: h.res = 3'd1;
            15'o10006: h.res = 3'd1;
            15'o10007: h.res = 3'd7;
            15'o10011: h.res = 3'd1;
            15'o10012: h.res = 3'd1;
            15'o10021: h.res = 3'd1;
            15'o10024: h.res = 3'd4;
            15'o10027: h.res = 3'd7;
            15'o10051: h.res = 3'd1;
            15'o10101: h.res = 3'd1;
            15'o10111: h.res = 3'd1;
            15'o10124: h.res = 3'd4;
            15'o10127: h.res = 3'd7;
            15'o10202: h.res = 3'd6;
            15'o10212: h.res = 3'd1;
            15'o10221: h.res = 3'd1;
            15'o10224: h.res = 3'd4;
            15'o10226: h.res = 3'd3;
            15'o10227: h.res = 3'd7;
            15'o10232: h.res = 3'd7;
            15'o10242: h.res = 3'd4;
            15'o10262: h.res = 3'd6;
            15'o10264: h.res = 3'd4;
            15'o10267: h.res = 3'd7;
            15'o10271: h.res = 3'd0;
            15'o10272: h.res = 3'd7;
            15'o10542: h.res = 3'd7;
            15'o11112: h.res = 3'd1;
            15'o11122: h.res = 3'd1;
            15'o11124: h.res = 3'd4;
            15'o11125: h.res = 3'd1;
            15'o11126: h.res = 3'd1;
            15'o11127: h.res = 3'd7;
            15'o11152: h.res = 3'd2;
            15'o11212: h.res = 3'd1;
            15'o11222: h.res = 3'd1;
            15'o11224: h.res = 3'd4;
            15'o11225: h.res = 3'd1;
            15'o11227: h.res = 3'd7;
            15'o11232: h.res = 3'd1;
            15'o11242: h.res = 3'd4;
            15'o11262: h.res = 3'd1;
            15'o11272: h.res = 3'd7;
            15'o11322: h.res = 3'd1;
            15'o12224: h.res = 3'd4;
            15'o12227: h.res = 3'd7;
            15'o12243: h.res = 3'd4;
            15'o12254: h.res = 3'd7;
            15'o12324: h.res = 3'd4;
            15'o12327: h.res = 3'd7;
            15'o12425: h.res = 3'd5;
            15'o12426: h.res = 3'd7;
            15'o12527: h.res = 3'd5;
            15'o20001: h.res = 3'd2;
            15'o20002: h.res = 3'd2;
            15'o20004: h.res = 3'd2;
            15'o20007: h.res = 3'd1;
            15'o20012: h.res = 3'd2;
            15'o20015: h.res = 3'd2;
            15'o20021: h.res = 3'd2;
            15'o20022: h.res = 3'd2;
            15'o20023: h.res = 3'd2;
            15'o20024: h.res = 3'd2;
            15'o20025: h.res = 3'd0;
            15'o20026: h.res = 3'd2;
            15'o20027: h.res = 3'd2;
            15'o20032: h.res = 3'd6;
            15'o20042: h.res = 3'd3;
            15'o20051: h.res = 3'd7;
            15'o20052: h.res = 3'd2;
            15'o20057: h.res = 3'd5;
            15'o20072: h.res = 3'd2;
            15'o20102: h.res = 3'd2;
            15'o20112: h.res = 3'd2;
            15'o20122: h.res = 3'd2;
            15'o20142: h.res = 3'd2;
            15'o20172: h.res = 3'd2;
            15'o20202: h.res = 3'd2;
            15'o20203: h.res = 3'd2;
            15'o20205: h.res = 3'd2;
            15'o20207: h.res = 3'd3;
            15'o20212: h.res = 3'd2;
            15'o20215: h.res = 3'd2;
            15'o20221: h.res = 3'd2;
            15'o20222: h.res = 3'd2;
            15'o20227: h.res = 3'd2;
            15'o20232: h.res = 3'd1;
            15'o20242: h.res = 3'd2;
            15'o20245: h.res = 3'd2;
            15'o20252: h.res = 3'd0;
            15'o20255: h.res = 3'd2;
            15'o20262: h.res = 3'd2;
            15'o20272: h.res = 3'd2;
            15'o20312: h.res = 3'd2;
            15'o20321: h.res = 3'd6;
            15'o20322: h.res = 3'd6;
            15'o20342: h.res = 3'd2;
            15'o20422: h.res = 3'd2;
            15'o20512: h.res = 3'd2;
            15'o20521: h.res = 3'd2;
            15'o20522: h.res = 3'd2;
            15'o20552: h.res = 3'd1;
            15'o20572: h.res = 3'd5;
            15'o20622: h.res = 3'd2;
            15'o20672: h.res = 3'd2;
            15'o20712: h.res = 3'd2;
            15'o20722: h.res = 3'd2;
            15'o20742: h.res = 3'd2;
            15'o20772: h.res = 3'd2;
            15'o21122: h.res = 3'd2;
            15'o21126: h.res = 3'd1;
            15'o21222: h.res = 3'd2;
            15'o21224: h.res = 3'd2;
            15'o21226: h.res = 3'd2;
            15'o21227: h.res = 3'd2;
            15'o21422: h.res = 3'd2;
            15'o21522: h.res = 3'd2;
            15'o21622: h.res = 3'd2;
            15'o21722: h.res = 3'd2;
            15'o22227: h.res = 3'd2;
            15'o22244: h.res = 3'd2;
            15'o22246: h.res = 3'd2;
            15'o22276: h.res = 3'd2;
            15'o22277: h.res = 3'd2;
            15'o30001: h.res = 3'd3;
            15'o30002: h.res = 3'd2;
            15'o30004: h.res = 3'd1;
            15'o30007: h.res = 3'd6;
            15'o30012: h.res = 3'd3;
            15'o30042: h.res = 3'd1;
            15'o30062: h.res = 3'd2;
            15'o30102: h.res = 3'd1;
            15'o30122: h.res = 3'd0;
            15'o30251: h.res = 3'd1;
            15'o40112: h.res = 3'd0;
            15'o40122: h.res = 3'd0;
            15'o40125: h.res = 3'd0;
            15'o40212: h.res = 3'd0;
            15'o40222: h.res = 3'd1;
            15'o40232: h.res = 3'd6;
            15'o40252: h.res = 3'd0;
            15'o40322: h.res = 3'd1;
            15'o50002: h.res = 3'd2;
            15'o50021: h.res = 3'd5;
            15'o50022: h.res = 3'd5;
            15'o50023: h.res = 3'd2;
            15'o50027: h.res = 3'd2;
            15'o50052: h.res = 3'd0;
            15'o50202: h.res = 3'd2;
            15'o50212: h.res = 3'd2;
            15'o50215: h.res = 3'd2;
            15'o50222: h.res = 3'd0;
            15'o50224: h.res = 3'd4;
            15'o50272: h.res = 3'd2;
            15'o51212: h.res = 3'd2;
            15'o51222: h.res = 3'd0;
            15'o51242: h.res = 3'd2;
            15'o51272: h.res = 3'd2;
            15'o60001: h.res = 3'd1;
            15'o60002: h.res = 3'd1;
            15'o60212: h.res = 3'd0;
            15'o61212: h.res = 3'd5;
            15'o61213: h.res = 3'd1;
            15'o61222: h.res = 3'd5;
            15'o70007: h.res = 3'd7;
            15'o70112: h.res = 3'd0;
            15'o70122: h.res = 3'd0;
            15'o70125: h.res = 3'd0;
            15'o70212: h.res = 3'd0;
            15'o70222: h.res = 3'd1;
            15'o70225: h.res = 3'd1;
            15'o70232: h.res = 3'd1;
            15'o70252: h.res = 3'd5;
            15'o70272: h.res = 3'd0;
            default: h.found = 1'b0;
        endcase
        return h;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/llcu_lookup.sv -----
// Lookup stage: four rotated keys checked against the rule table, results registered.
// Depends on llcu_pkg.
`default_nettype none
module llcu_lookup import llcu_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   advance,
    input  wire logic   in_valid,
    input  wire state_t c_in,
    input  wire state_t n_in,
    input  wire state_t e_in,
    input  wire state_t s_in,
    input  wire state_t w_in,
    output logic        out_valid,
    output state_t      c_out,
    output hit_t [3:0]  hits
);
    logic       valid_reg;
    state_t     c_reg;
    hit_t [3:0] hits_reg;
    hit_t [3:0] hits_next;

    always_comb begin
        hits_next[0] = rule_lookup({c_in, n_in, e_in, s_in, w_in});
        hits_next[1] = rule_lookup({c_in, e_in, s_in, w_in, n_in});
        hits_next[2] = rule_lookup({c_in, s_in, w_in, n_in, e_in});
        hits_next[3] = rule_lookup({c_in, w_in, n_in, e_in, s_in});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
        if (advance) begin
            c_reg    <= c_in;
            hits_reg <= hits_next;
        end
    end

    assign out_valid = valid_reg;
    assign c_out     = c_reg;
    assign hits      = hits_reg;
endmodule
`default_nettype wire

// ----- rtl/langton_loop_cell_update.sv -----
// Langton's loop cell update: one neighborhood word in, one next-state word out.
// Registered stages in order: input register, table lookup, rotation select; throughput one word
// per cycle while m_tready does not stall, with one table lookup per rotation in a single stage.
// A stall on m_tready freezes all stages together.
// Synchronous active-low reset clears the valid bits; no other state.
// Depends on llcu_pkg and llcu_lookup.
`default_nettype none
module langton_loop_cell_update import llcu_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,  // center, north, east, south, west (3 bits each)
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,  // next_state
    output logic [0:0]       m_tuser   // rule_found
);
    logic       advance;
    logic       v1_reg;
    state_t     c1_reg, n1_reg, e1_reg, s1_reg, w1_reg;
    logic       v2;
    state_t     c2;
    hit_t [3:0] hits2;
    logic       v3_reg;
    state_t     ns3_reg, ns3_next, c3_reg;
    logic       f3_reg, f3_next;

    assign advance  = m_tready || !v3_reg;
    assign s_tready = advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= s_tvalid;
            v3_reg <= v2;
        end
        if (advance) begin
            c1_reg  <= s_tdata[2:0];
            n1_reg  <= s_tdata[5:3];
            e1_reg  <= s_tdata[8:6];
            s1_reg  <= s_tdata[11:9];
            w1_reg  <= s_tdata[14:12];
            ns3_reg <= ns3_next;
            f3_reg  <= f3_next;
            c3_reg  <= c2;
        end
    end

    llcu_lookup u_lookup (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (v1_reg),
        .c_in      (c1_reg),
        .n_in      (n1_reg),
        .e_in      (e1_reg),
        .s_in      (s1_reg),
        .w_in      (w1_reg),
        .out_valid (v2),
        .c_out     (c2),
        .hits      (hits2)
    );

    always_comb begin
        f3_next  = 1'b1;
        ns3_next = c2;
        if (hits2[0].found)      ns3_next = hits2[0].res;
        else if (hits2[1].found) ns3_next = hits2[1].res;
        else if (hits2[2].found) ns3_next = hits2[2].res;
        else if (hits2[3].found) ns3_next = hits2[3].res;
        else                     f3_next  = 1'b0;
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {5'b0, ns3_reg};
    assign m_tuser  = f3_reg;

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");
    a_no_match_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !f3_reg) |-> (ns3_reg == c3_reg))
        else $error("unmatched cell changed state");
    a_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && v2) |=> m_tvalid)
        else $error("lookup word lost");
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (!advance) |=> (v1_reg == $past(v1_reg) && v2 == $past(v2)))
        else $error("pipeline moved during stall");
endmodule
`default_nettype wire
